// ===== sv/mkd_pkg.sv =====
// Package for the Morse key decoder: register codes, widths, reset values,
// the character table and its lookup function. No dependencies.

package mkd_pkg;

  localparam int CntW     = 16;
  localparam int LenW     = 3;
  localparam int BitsW    = 8;
  localparam int CharW    = 7;
  localparam int RegIdxW  = 2;
  localparam int TabSize  = 38;

  localparam logic [CntW-1:0]  CntMax       = '1;
  localparam logic [CntW-1:0]  MinPressRst  = 16'd100;
  localparam logic [CntW-1:0]  DotLimitRst  = 16'd200;
  localparam logic [CntW-1:0]  DashLimitRst = 16'd400;
  localparam logic [CntW-1:0]  GapTimeRst   = 16'd400;
  localparam logic [BitsW-1:0] FirstBit     = 8'h80;
  localparam logic [CharW-1:0] SpaceChar    = 7'h20;

  typedef enum logic [RegIdxW-1:0] {
    REG_MIN_PRESS   = 2'd0,
    REG_DOT_LIMIT   = 2'd1,
    REG_DASH_LIMIT  = 2'd2,
    REG_GAP_TIMEOUT = 2'd3
  } mkd_reg_t;

  typedef struct packed {
    logic [CntW-1:0] min_press;
    logic [CntW-1:0] dot_limit;
    logic [CntW-1:0] dash_limit;
    logic [CntW-1:0] gap_timeout;
  } mkd_cfg_t;

  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] letter;
    logic [LenW-1:0]  symbol_count;
    logic [BitsW-1:0] pattern;
  } mkd_result_t;

  localparam logic [LenW-1:0] TAB_LEN [TabSize] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd5
  };

  localparam logic [BitsW-1:0] TAB_BITS [TabSize] = '{
    8'h40, 8'h80, 8'ha0, 8'h80, 8'h00, 8'h20, 8'hc0, 8'h00, 8'h00, 8'h70, 8'ha0,
    8'h40, 8'hc0, 8'h80, 8'he0, 8'h60, 8'hd0, 8'h40, 8'h00, 8'h80, 8'h20, 8'h10,
    8'h60, 8'h90, 8'hb0, 8'hc0, 8'h78, 8'h38, 8'h18, 8'h08, 8'h00, 8'h80, 8'hc0,
    8'he0, 8'hf0, 8'hf8, 8'h30, 8'h90
  };

  // Letters A to Z, then digits 1 to 9 and 0, then question mark and slash.
  localparam logic [CharW-1:0] TAB_CHAR [TabSize] = '{
    7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4a, 7'h4b,
    7'h4c, 7'h4d, 7'h4e, 7'h4f, 7'h50, 7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56,
    7'h57, 7'h58, 7'h59, 7'h5a, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h30, 7'h3f, 7'h2f
  };

  // All entries are compared in parallel; the lowest matching entry wins.
  function automatic logic [CharW-1:0] lookup_letter(input logic [LenW-1:0]  len,
                                                     input logic [BitsW-1:0] bits);
    logic [CharW-1:0] res;
    res = SpaceChar;
    for (int k = TabSize - 1; k >= 0; k--) begin
      if (TAB_LEN[k] == len && TAB_BITS[k] == bits) begin
        res = TAB_CHAR[k];
      end
    end
    return res;
  endfunction

endpackage

// ===== sv/mkd_if.sv =====
// Valid/ready channel interfaces for the key samples and the decoded characters.
// Depends on mkd_pkg for field widths.

interface mkd_key_if;
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink   (input valid, input key_level, output ready);
endinterface

interface mkd_char_if import mkd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] letter;
  logic [LenW-1:0]  symbol_count;
  logic [BitsW-1:0] pattern;

  modport source (output valid, output letter, output symbol_count, output pattern,
                  input ready);
  modport sink   (input valid, input letter, input symbol_count, input pattern,
                  output ready);
endinterface

// ===== sv/mkd_cfg_regs.sv =====
// Register bank for the four timing thresholds of the Morse key decoder.
// Depends on mkd_pkg.

module mkd_cfg_regs import mkd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [RegIdxW-1:0] cfg_index,
  input  logic [CntW-1:0]    cfg_data,
  output mkd_cfg_t           cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_press   <= MinPressRst;
      cfg.dot_limit   <= DotLimitRst;
      cfg.dash_limit  <= DashLimitRst;
      cfg.gap_timeout <= GapTimeRst;
    end else if (cfg_write) begin
      case (mkd_reg_t'(cfg_index))
        REG_MIN_PRESS:   cfg.min_press   <= cfg_data;
        REG_DOT_LIMIT:   cfg.dot_limit   <= cfg_data;
        REG_DASH_LIMIT:  cfg.dash_limit  <= cfg_data;
        REG_GAP_TIMEOUT: cfg.gap_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/mkd_tick_core.sv =====
// Per-tick decoder state: press and gap timers, symbol classification, pattern
// accumulation and the character decision. Depends on mkd_pkg.

module mkd_tick_core import mkd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        key_level,
  input  mkd_cfg_t    cfg,
  output mkd_result_t res
);

  logic             previous_level, previous_level_next;
  logic [CntW-1:0]  press_ticks, press_ticks_next;
  logic [CntW-1:0]  gap_ticks, gap_ticks_next;
  logic             char_pending, char_pending_next;
  logic [LenW-1:0]  symbol_length, symbol_length_next;
  logic [BitsW-1:0] symbol_bits, symbol_bits_next;

  logic [CntW-1:0]  press_run;
  logic [CntW-1:0]  gap_run;
  logic             release_edge;
  logic             in_range;
  logic             is_dot;
  logic             is_dash;
  logic [LenW-1:0]  len_acc;
  logic [BitsW-1:0] bits_acc;
  logic             pend_acc;
  logic [CntW-1:0]  gap_acc;
  logic             emit;

  always_comb begin
    gap_run   = (char_pending && gap_ticks != CntMax) ? gap_ticks + 1'b1 : gap_ticks;
    press_run = (!previous_level && press_ticks != CntMax) ? press_ticks + 1'b1
                                                           : press_ticks;

    release_edge = key_level && !previous_level;
    in_range     = press_run >= cfg.min_press;
    is_dot       = release_edge && in_range && press_run < cfg.dot_limit;
    is_dash      = release_edge && in_range && !(press_run < cfg.dot_limit) &&
                   press_run < cfg.dash_limit;

    len_acc  = symbol_length;
    bits_acc = symbol_bits;
    pend_acc = char_pending;
    gap_acc  = gap_run;
    if (is_dot || is_dash) begin
      if (is_dash) begin
        bits_acc = symbol_bits | (FirstBit >> symbol_length);
      end
      len_acc  = symbol_length + 1'b1;
      gap_acc  = '0;
      pend_acc = 1'b1;
    end

    emit = pend_acc && gap_acc > cfg.gap_timeout;

    res.valid        = step && emit;
    res.letter       = lookup_letter(len_acc, bits_acc);
    res.symbol_count = len_acc;
    res.pattern      = bits_acc;

    previous_level_next = key_level;
    press_ticks_next    = (!key_level && previous_level) ? '0 : press_run;
    gap_ticks_next      = gap_acc;
    char_pending_next   = emit ? 1'b0 : pend_acc;
    symbol_length_next  = emit ? '0 : len_acc;
    symbol_bits_next    = emit ? '0 : bits_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= 1'b1;
      press_ticks    <= '0;
      gap_ticks      <= '0;
      char_pending   <= 1'b0;
      symbol_length  <= '0;
      symbol_bits    <= '0;
    end else if (step) begin
      previous_level <= previous_level_next;
      press_ticks    <= press_ticks_next;
      gap_ticks      <= gap_ticks_next;
      char_pending   <= char_pending_next;
      symbol_length  <= symbol_length_next;
      symbol_bits    <= symbol_bits_next;
    end
  end

endmodule

// ===== sv/morse_key_decoder_unit.sv =====
// Top level of the Morse key decoder: input register, tick core, result register.
// Depends on mkd_pkg, mkd_if, mkd_cfg_regs and mkd_tick_core.
//
//   Channel    Role      Beat carries                          Rule
//   key        sink      key_level (0 pressed, 1 released)     one beat per ms tick
//   result     source    letter, symbol_count, pattern         zero or one per tick
//   cfg_*      write     cfg_index, cfg_data (16 bits)         write while idle
//
// Each key beat is captured in an input register; when the core steps, it updates
// its timers and pattern and may load the result register. The block sustains one
// key beat per cycle while the result channel does not stall. Reset is synchronous
// and restores the default thresholds and a released key. A stall on the result
// channel holds the input register, and key is refused only while both the input
// and the result register are occupied.

module morse_key_decoder_unit import mkd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [RegIdxW-1:0] cfg_index,
  input  logic [CntW-1:0]    cfg_data,
  mkd_key_if.sink            key,
  mkd_char_if.source         result
);

  mkd_cfg_t    cfg;
  mkd_result_t core_res;

  // Input register: one key sample waiting for the core.
  logic in_valid;
  logic in_level;

  // Result register: one decoded character waiting for the sink.
  logic             out_valid;
  logic [CharW-1:0] out_letter;
  logic [LenW-1:0]  out_count;
  logic [BitsW-1:0] out_pattern;

  logic can_step;
  logic step;

  // The core may run whenever the result register is free or drains this cycle,
  // since a tick produces at most one character.
  assign can_step  = !out_valid || result.ready;
  assign step      = in_valid && can_step;
  assign key.ready = !in_valid || can_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (key.ready) begin
      in_valid <= key.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (key.ready && key.valid) begin
      in_level <= key.key_level;
    end
  end

  mkd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mkd_tick_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .key_level (in_level),
    .cfg       (cfg),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_step) begin
      out_valid <= core_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res.valid && can_step) begin
      out_letter  <= core_res.letter;
      out_count   <= core_res.symbol_count;
      out_pattern <= core_res.pattern;
    end
  end

  assign result.valid        = out_valid;
  assign result.letter       = out_letter;
  assign result.symbol_count = out_count;
  assign result.pattern      = out_pattern;

endmodule

// ===== sv/mkd_checker.sv =====
// Port-level checker for the Morse key decoder, bound to the top level.
// Depends on mkd_pkg.

module mkd_checker import mkd_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CharW-1:0] letter,
  input logic [LenW-1:0]  symbol_count,
  input logic [BitsW-1:0] pattern
);

  // A waiting character stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(letter) && $stable(pattern))
    else $error("result beat dropped or changed while stalled");

  // With the result side empty, the key side is never refused.
  a_key_flow: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("key refused while result register empty");

  // An empty pattern never matches a table entry.
  a_empty_space: assert property (@(posedge clk) disable iff (rst)
    out_valid && symbol_count == '0 |-> letter == SpaceChar)
    else $error("empty pattern decoded to a character");

  // A matched character has no pattern bits past its symbol count.
  a_match_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && letter != SpaceChar |-> (pattern & (8'hff >> symbol_count)) == '0)
    else $error("decoded character with stray pattern bits");

endmodule

bind morse_key_decoder_unit mkd_checker u_mkd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (key.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .letter       (result.letter),
  .symbol_count (result.symbol_count),
  .pattern      (result.pattern)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for morse_key_decoder_unit: key samples in, decoded characters out.
// Depends on mkd_pkg, the channel interfaces in mkd_if and the decoder RTL.
`timescale 1ns / 100ps

module testbench;
  import mkd_pkg::*;

  // One decoded character as it leaves the result channel.
  typedef struct packed {
    logic [CharW-1:0] letter;
    logic [LenW-1:0]  count;
    logic [BitsW-1:0] pattern;
  } char_beat_t;

  // One directed row: optionally new thresholds, then a string of key marks, then a
  // released tail. Marks: '.' dot, '-' dash, 'b' bounce, 'o' overlong, 'h' a hold that
  // outlasts the gap timeout, 'L' a hold long enough to saturate the press counter.
  typedef struct {
    logic        set_cfg;
    mkd_cfg_t    cfg;
    string       marks;
    int          tail;
    logic        typed;
    char_beat_t  want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic               cfg_write;
  logic [RegIdxW-1:0] cfg_index;
  logic [CntW-1:0]    cfg_data;

  mkd_key_if  key_ch ();
  mkd_char_if char_ch ();

  morse_key_decoder_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key_ch),
    .result    (char_ch)
  );

  always #1 clk = ~clk;

  // Morse code of each character, dot and dash spelled out, in the order of the glyphs.
  string morse_codes [38] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---", "-.-",
    ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-", "..-", "...-",
    ".--", "-..-", "-.--", "--..", ".----", "..---", "...--", "....-", ".....",
    "-....", "--...", "---..", "----.", "-----", "..--..", "-..-."
  };
  string morse_glyphs = "ABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890?/";

  // Shadow copy of the thresholds and of the decoder state.
  mkd_cfg_t         thresholds;
  logic             prev_level;
  logic [CntW-1:0]  press_len;
  logic [CntW-1:0]  gap_len;
  logic             char_open;
  logic [LenW-1:0]  mark_count;
  logic [BitsW-1:0] mark_bits;

  // Characters predicted but not yet seen on the result channel, oldest first.
  char_beat_t pending_chars [$];

  // A directed row may carry a hand-written character that stands in for the
  // prediction of the first character decoded during that row.
  logic       typed_hold;
  char_beat_t typed_char;

  int send_idle_pct;
  int recv_stall_pct;
  int error_count;
  int tick_count;
  int char_count;

  // Directed rows. The first two run at the reset thresholds, most of the rest at small
  // ones so that each letter takes a handful of ticks.
  dir_row_t dir_rows [20] = '{
    // Reset thresholds: a 100-tick press is a dot, a 200-tick press a dash.
    '{1'b0, '0, ".", 402, 1'b1, {7'h45, 3'd1, 8'h00}},                     // E
    '{1'b0, '0, "-", 402, 1'b1, {7'h54, 3'd1, 8'h80}},                     // T
    '{1'b1, {16'd2, 16'd4, 16'd8, 16'd10}, ".-", 12, 1'b1,
      {7'h41, 3'd2, 8'h40}},                                                // A
    '{1'b0, '0, "-...", 12, 1'b1, {7'h42, 3'd4, 8'h80}},                   // B
    '{1'b0, '0, "..--..", 12, 1'b1, {7'h3f, 3'd6, 8'h30}},                 // ?
    '{1'b0, '0, "-..-.", 12, 1'b1, {7'h2f, 3'd5, 8'h90}},                  // /
    '{1'b0, '0, "-----", 12, 1'b1, {7'h30, 3'd5, 8'hf8}},                  // 0
    // Bounce and overlong presses leave the pattern alone.
    '{1'b0, '0, ".b-o", 12, 1'b1, {7'h41, 3'd2, 8'h40}},                   // A
    // Seven dashes match nothing and decode to a space.
    '{1'b0, '0, "-------", 12, 1'b1, {7'h20, 3'd7, 8'hfe}},
    // The eighth symbol wraps the length to zero with the bits still set.
    '{1'b0, '0, "--------", 12, 1'b1, {7'h20, 3'd0, 8'hff}},
    // Eight dots wrap to an empty length, and the ninth symbol reads as a lone dash.
    '{1'b0, '0, "........-", 12, 1'b1, {7'h54, 3'd1, 8'h80}},              // T
    // The character comes out while the key is still held.
    '{1'b0, '0, ".h", 12, 1'b0, '0},
    // Minimum press above the dot limit: every counted press is a dash.
    '{1'b1, {16'd6, 16'd3, 16'd9, 16'd10}, "..", 12, 1'b0, '0},
    // No bounce filter and open-ended dot range; a 65535-tick press is overlong.
    '{1'b1, {16'd0, 16'hffff, 16'hffff, 16'd10}, ".-", 12, 1'b0, '0},
    // A press past the counter's range must stay saturated, not wrap into a dot.
    '{1'b0, '0, "L", 12, 1'b0, '0},
    // Largest gap timeout: the gap counter saturates and nothing comes out.
    '{1'b1, {16'd2, 16'd4, 16'd8, 16'hffff}, ".", 66000, 1'b0, '0},
    // Dropping the timeout releases the waiting character on the next tick.
    '{1'b1, {16'd2, 16'd4, 16'd8, 16'd0}, "", 1, 1'b1, {7'h45, 3'd1, 8'h00}},
    '{1'b0, '0, "-", 3, 1'b1, {7'h54, 3'd1, 8'h80}},                       // T
    // Zero limits: every press is overlong.
    '{1'b1, {16'd0, 16'd0, 16'd0, 16'd5}, "...", 8, 1'b0, '0},
    // Largest minimum press: just under it is still bounce.
    '{1'b1, {16'hffff, 16'd0, 16'd0, 16'd0}, "b", 3, 1'b0, '0}
  };

  task automatic flag_mismatch(input string msg);
    error_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Character for a length and pattern, or a space when no code matches. An empty
  // length matches nothing, since every code has at least one mark.
  function automatic logic [CharW-1:0] morse_char(input logic [LenW-1:0]  len,
                                                  input logic [BitsW-1:0] bits);
    logic [BitsW-1:0] code_bits;
    for (int e = 0; e < 38; e++) begin
      code_bits = '0;
      for (int k = 0; k < morse_codes[e].len(); k++) begin
        if (morse_codes[e][k] == "-") begin
          code_bits[BitsW-1-k] = 1'b1;
        end
      end
      if (morse_codes[e].len() == int'(len) && code_bits == bits) begin
        return CharW'(morse_glyphs[e]);
      end
    end
    return 7'h20;
  endfunction

  // Advances the shadow decoder by one key sample; fired tells whether a character
  // is decoded on this tick.
  function automatic void decode_tick(input logic level, output logic fired,
                                      output char_beat_t beat);
    logic counted;
    logic is_dash;
    fired = 1'b0;
    beat  = '0;
    if (char_open && gap_len != '1) begin
      gap_len++;
    end
    if (!prev_level && press_len != '1) begin
      press_len++;
    end
    if (level != prev_level) begin
      if (!level) begin
        press_len = '0;
      end else begin
        // Classified in register order, with no assumption that the limits ascend.
        counted = press_len >= thresholds.min_press &&
                  (press_len < thresholds.dot_limit || press_len < thresholds.dash_limit);
        is_dash = press_len >= thresholds.dot_limit;
        if (counted) begin
          if (is_dash) begin
            mark_bits = mark_bits | (8'h80 >> mark_count);
          end
          mark_count = mark_count + 1'b1;
          gap_len    = '0;
          char_open  = 1'b1;
        end
      end
      prev_level = level;
    end
    if (char_open && gap_len > thresholds.gap_timeout) begin
      fired      = 1'b1;
      beat       = '{morse_char(mark_count, mark_bits), mark_count, mark_bits};
      char_open  = 1'b0;
      mark_count = '0;
      mark_bits  = '0;
    end
  endfunction

  // Sends n beats of one key level, idling at random before each, and records the
  // characters that each accepted beat should produce.
  task automatic key_run(input logic lvl, input int n);
    logic       fired;
    char_beat_t beat;
    repeat (n) begin
      while ($urandom_range(99) < send_idle_pct) begin
        key_ch.valid <= 1'b0;
        @(posedge clk);
      end
      key_ch.valid     <= 1'b1;
      key_ch.key_level <= lvl;
      @(posedge clk);
      while (!key_ch.ready) begin
        @(posedge clk);
      end
      decode_tick(lvl, fired, beat);
      tick_count++;
      if (fired) begin
        char_count++;
        pending_chars.push_back(typed_hold ? typed_char : beat);
        typed_hold = 1'b0;
      end
    end
  endtask

  task automatic key_pulse(input int press, input int release_len);
    key_run(1'b0, (press < 1) ? 1 : press);
    key_run(1'b1, release_len);
  endtask

  // Stops the key channel and waits until every predicted character has arrived,
  // then lets the clock run on, since a beat that decodes nothing may still be in flight.
  task automatic settle();
    int waited;
    waited = 0;
    key_ch.valid <= 1'b0;
    while (pending_chars.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_thresholds(input mkd_cfg_t c);
    cfg_write <= 1'b1;
    cfg_index <= REG_MIN_PRESS;
    cfg_data  <= c.min_press;
    @(posedge clk);
    cfg_index <= REG_DOT_LIMIT;
    cfg_data  <= c.dot_limit;
    @(posedge clk);
    cfg_index <= REG_DASH_LIMIT;
    cfg_data  <= c.dash_limit;
    @(posedge clk);
    cfg_index <= REG_GAP_TIMEOUT;
    cfg_data  <= c.gap_timeout;
    @(posedge clk);
    cfg_write  <= 1'b0;
    thresholds = c;
  endtask

  task automatic play_row(input dir_row_t r);
    int hold;
    if (r.set_cfg) begin
      settle();
      write_thresholds(r.cfg);
    end
    typed_hold = r.typed;
    typed_char = r.want;
    for (int i = 0; i < r.marks.len(); i++) begin
      case (r.marks[i])
        ".":     hold = int'(thresholds.min_press);
        "-":     hold = int'(thresholds.dot_limit);
        "b":     hold = int'(thresholds.min_press) - 1;
        "o":     hold = int'(thresholds.dash_limit);
        "h":     hold = int'(thresholds.gap_timeout) + 5;
        default: hold = 70000;
      endcase
      key_pulse(hold, (i == r.marks.len() - 1) ? r.tail : 2);
    end
    if (r.marks.len() == 0) begin
      key_run(1'b1, r.tail);
    end
    typed_hold = 1'b0;
  endtask

  function automatic int pick_between(input int lo, input int hi);
    if (hi <= lo) begin
      return lo;
    end
    return int'($urandom_range(hi, lo));
  endfunction

  // Mostly ascending small thresholds with a gap timeout above the longest counted
  // press, so that letters come out whole; now and then an unordered set.
  task automatic random_setting();
    mkd_cfg_t c;
    if ($urandom_range(5) == 0) begin
      c.min_press   = CntW'($urandom_range(12));
      c.dot_limit   = CntW'($urandom_range(12));
      c.dash_limit  = CntW'($urandom_range(12));
      c.gap_timeout = CntW'($urandom_range(20));
    end else begin
      c.min_press   = CntW'($urandom_range(3));
      c.dot_limit   = CntW'(c.min_press + $urandom_range(4, 1));
      c.dash_limit  = CntW'(c.dot_limit + $urandom_range(6, 1));
      c.gap_timeout = CntW'(c.dash_limit + $urandom_range(12, 1));
    end
    settle();
    write_thresholds(c);
  endtask

  // One letter's worth of key activity: usually a clean run of dots and dashes with
  // random lengths inside their windows, sometimes long enough to wrap the length,
  // and otherwise a burst of arbitrary presses.
  task automatic random_letter();
    int n;
    int gap;
    int press;
    gap = int'(thresholds.gap_timeout);
    if ($urandom_range(4) == 0) begin
      n = $urandom_range(4, 1);
      repeat (n) begin
        key_pulse(pick_between(1, int'(thresholds.dash_limit) + 3), pick_between(1, gap + 3));
      end
    end else begin
      n = ($urandom_range(7) == 0) ? $urandom_range(10, 7) : $urandom_range(6, 1);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(1)) begin
          press = pick_between(int'(thresholds.dot_limit), int'(thresholds.dash_limit) - 1);
        end else begin
          press = pick_between(int'(thresholds.min_press), int'(thresholds.dot_limit) - 1);
        end
        key_pulse(press, (i == n - 1) ? gap + $urandom_range(6, 2) : $urandom_range(2, 1));
      end
    end
  endtask

  // Result side: ready is redrawn every cycle according to the stall rate.
  initial begin
    char_ch.ready = 1'b1;
    forever begin
      @(posedge clk);
      char_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every accepted character is checked against the oldest prediction, field by field.
  always @(posedge clk) begin
    char_beat_t want;
    if (!rst && char_ch.valid && char_ch.ready) begin
      if (pending_chars.size() == 0) begin
        flag_mismatch($sformatf("character %h arrived with none expected", char_ch.letter));
      end else begin
        want = pending_chars.pop_front();
        if (char_ch.letter != want.letter) begin
          flag_mismatch($sformatf("letter %h, expected %h", char_ch.letter, want.letter));
        end
        if (char_ch.symbol_count != want.count) begin
          flag_mismatch($sformatf("symbol_count %0d, expected %0d",
                                  char_ch.symbol_count, want.count));
        end
        if (char_ch.pattern != want.pattern) begin
          flag_mismatch($sformatf("pattern %h, expected %h", char_ch.pattern, want.pattern));
        end
      end
    end
  end

  initial begin
    int t0;
    int c0;
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = REG_MIN_PRESS;
    cfg_data         = '0;
    key_ch.valid     = 1'b0;
    key_ch.key_level = 1'b1;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    error_count      = 0;
    tick_count       = 0;
    char_count       = 0;
    typed_hold       = 1'b0;
    typed_char       = '0;
    thresholds       = {MinPressRst, DotLimitRst, DashLimitRst, GapTimeRst};
    prev_level       = 1'b1;
    press_len        = '0;
    gap_len          = '0;
    char_open        = 1'b0;
    mark_count       = '0;
    mark_bits        = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed rows run back to back with no idling on either side.
    foreach (dir_rows[i]) begin
      play_row(dir_rows[i]);
    end

    // Random part, in four idling phases: none, sender idle half the time, receiver
    // stalling half the time, and both at a light rate. Each phase goes through three
    // threshold settings, each held for 70 ticks and five characters, or 1500 ticks.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 50 : (phase == 3) ? 14 : 0;
      recv_stall_pct = (phase == 2) ? 50 : (phase == 3) ? 14 : 0;
      repeat (3) begin
        random_setting();
        t0 = tick_count;
        c0 = char_count;
        while ((tick_count - t0 < 70 || char_count - c0 < 5) && tick_count - t0 < 1500) begin
          random_letter();
        end
      end
    end

    settle();
    if (pending_chars.size() != 0) begin
      flag_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
    end
    if (error_count == 0) begin
      $display("PASS morse_key_decoder_unit");
    end else begin
      $display("FAIL morse_key_decoder_unit");
    end
    $finish;
  end

  // Guard against a hung handshake; several times the longest correct run.
  initial begin
    #3000000;
    $display("FAIL morse_key_decoder_unit");
    $finish;
  end

endmodule
